>>> src/arc_pkg.sv
// arc_pkg: operation codes, field widths and default sizes for arrangement_cutwidth.
// No dependencies; imported by the top level.
package arc_pkg;

  localparam int OP_W    = 2;
  localparam int VERT_W  = 10;
  localparam int POS_W   = 11;
  localparam int CNT_VAL_W = 16;
  localparam int OUT_W   = 17;
  // wide enough to compare any index against MAX_VERTICES (up to 65536)
  localparam int CMP_W   = 17;

  localparam int MAX_VERTICES_DEF = 1024;

  localparam logic [OP_W-1:0] OP_SET_LABEL = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_REPORT    = 2'd2;

  localparam logic [CNT_VAL_W-1:0] COUNT_MAX = '1;

endpackage

>>> src/arrangement_cutwidth.sv
// arrangement_cutwidth: cutwidth of a linear arrangement, position and counter
// memories driven by a small sequencer. Depends on arc_pkg.
//
// Operations: set label never raises busy. Add edge keeps busy high through two endpoint
// reads, then one active vertex per cycle through the position read port and the counter
// read-modify-write, plus pipeline drain. Report reads and clears all MAX_VERTICES counters,
// one per cycle, then gives a one-cycle result strobe.
// Reset: synchronous, active low; afterwards busy stays high while every counter is
// cleared. The receiver cannot stall the result.
module arrangement_cutwidth
  import arc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          in_operation,
  input  logic [VERT_W-1:0]        in_vertex_a,
  input  logic [VERT_W-1:0]        in_vertex_b,
  input  logic [POS_W-1:0]         in_label,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_max_cut,
  input  logic                     cfg_wr_en,
  input  logic [POS_W-1:0]         cfg_wr_data
);

  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int IDX_W = AW + 1;
  localparam logic [CMP_W-1:0] MAXW = CMP_W'(MAX_VERTICES);
  localparam logic [IDX_W-1:0] IDX_END = IDX_W'(MAX_VERTICES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EB    = 3'd1;
  localparam logic [2:0] S_SPAN  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;

  // control
  logic [2:0]           state_r, state_nxt;
  logic [POS_W-1:0]     num_r;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 emit_r, emit_nxt;
  logic                 s1_v_r, s1_v_nxt;
  logic                 s2_v_r, s2_v_nxt;
  logic                 fw_v_r;
  logic                 sw_v_r, sw_v_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // payload
  logic [VERT_W-1:0]    vb_r;
  logic                 oob_a_r, oob_b_r;
  logic [POS_W-1:0]     pa_r, pa_nxt;
  logic [POS_W-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [AW-1:0]        s2_addr_r;
  logic [AW-1:0]        fw_addr_r;
  logic [CNT_VAL_W-1:0] fw_data_r;
  logic [AW-1:0]        sw_idx_r, sw_idx_nxt;
  logic [CNT_VAL_W-1:0] best_r, best_nxt;
  logic [OUT_W-1:0]     out_r, out_nxt;

  // memories
  logic [POS_W-1:0]     pos_mem [MAX_VERTICES];
  logic [CNT_VAL_W-1:0] cut_mem [MAX_VERTICES];
  logic [POS_W-1:0]     pos_q;
  logic [CNT_VAL_W-1:0] cut_q;
  logic                 pos_we;
  logic [AW-1:0]        pos_wa, pos_ra;
  logic                 cut_we;
  logic [AW-1:0]        cut_wa, cut_ra;
  logic [CNT_VAL_W-1:0] cut_wd;

  logic [IDX_W-1:0]     n_eff;
  logic                 accept;
  logic                 oob_a, oob_b;
  logic [POS_W-1:0]     pb;
  logic                 hit;
  logic [CNT_VAL_W-1:0] old_cnt, inc_cnt;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign n_eff  = ({6'b0, num_r} > MAXW) ? IDX_END : IDX_W'(num_r);
  assign oob_a  = ({7'b0, in_vertex_a} >= MAXW);
  assign oob_b  = oob_b_r;
  assign pb     = oob_b ? '0 : pos_q;

  // span test of the walk's current position
  assign hit = s1_v_r && (pos_q >= lo_r) && (pos_q < hi_r) && ({6'b0, pos_q} < MAXW);

  // increment unit with saturation; forward the write of the previous cycle
  assign old_cnt = (fw_v_r && (fw_addr_r == s2_addr_r)) ? fw_data_r : cut_q;
  assign inc_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    emit_nxt      = emit_r;
    s1_v_nxt      = 1'b0;
    s2_v_nxt      = 1'b0;
    sw_v_nxt      = 1'b0;
    sw_idx_nxt    = sw_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    pa_nxt        = pa_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    best_nxt      = best_r;
    pos_we        = 1'b0;
    pos_wa        = AW'(in_vertex_a);
    pos_ra        = AW'(in_vertex_a);
    cut_we        = 1'b0;
    cut_wa        = s2_addr_r;
    cut_wd        = inc_cnt;
    cut_ra        = AW'(pos_q);

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_SET_LABEL: pos_we = !oob_a;
            OP_ADD_EDGE:  state_nxt = S_EB;
            OP_REPORT: begin
              state_nxt = S_SWEEP;
              idx_nxt   = '0;
              emit_nxt  = 1'b1;
              best_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_EB: begin
        pos_ra    = AW'(vb_r);
        pa_nxt    = oob_a_r ? '0 : pos_q;
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        lo_nxt    = (pa_r < pb) ? pa_r : pb;
        hi_nxt    = (pa_r < pb) ? pb : pa_r;
        idx_nxt   = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // position read -> span test / counter read -> counter write
        s2_v_nxt = hit;
        cut_we   = s2_v_r;
        if (idx_r != n_eff) begin
          pos_ra   = idx_r[AW-1:0];
          s1_v_nxt = 1'b1;
          idx_nxt  = idx_r + 1'b1;
        end else if (!s1_v_r && !s2_v_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_SWEEP: begin
        // read each counter and zero it in the same cycle; compare in the cycle after
        if (sw_v_r && ({1'b0, sw_idx_r} < n_eff) && (cut_q > best_r))
          best_nxt = cut_q;
        if (idx_r != IDX_END) begin
          cut_ra     = idx_r[AW-1:0];
          cut_wa     = idx_r[AW-1:0];
          cut_wd     = '0;
          cut_we     = 1'b1;
          sw_v_nxt   = 1'b1;
          sw_idx_nxt = idx_r[AW-1:0];
          idx_nxt    = idx_r + 1'b1;
        end else if (!sw_v_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = emit_r;
          out_nxt       = (n_eff == '0) ? '1 : {1'b0, best_r};
          emit_nxt      = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= in_label;
    pos_q <= pos_mem[pos_ra];
  end

  always_ff @(posedge clk) begin
    if (cut_we) cut_mem[cut_wa] <= cut_wd;
    cut_q <= cut_mem[cut_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      idx_r       <= '0;
      emit_r      <= 1'b0;
      num_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      fw_v_r      <= 1'b0;
      sw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      emit_r      <= emit_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_v_r      <= s2_v_nxt;
      fw_v_r      <= s2_v_r && (state_r == S_WALK);
      sw_v_r      <= sw_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) num_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vb_r    <= in_vertex_b;
      oob_a_r <= oob_a;
      oob_b_r <= ({7'b0, in_vertex_b} >= MAXW);
    end
    pa_r      <= pa_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    s2_addr_r <= AW'(pos_q);
    fw_addr_r <= s2_addr_r;
    fw_data_r <= inc_cnt;
    sw_idx_r  <= sw_idx_nxt;
    best_r    <= best_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_max_cut = out_r;

  // a result only follows the end of a counter sweep
  a_out_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_SWEEP))
    else $error("result without a completed sweep");

  // block is idle again when the result is shown
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result while busy");

  // counters are only written by the walk or the sweep
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !cut_we)
    else $error("counter write while idle");

  // no positions in use reports all ones
  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (n_eff == '0)) |-> (out_r == '1))
    else $error("empty report not all ones");

endmodule

>>> tb/sv/testbench.sv
// testbench: self-checking bench for arrangement_cutwidth, with a scoreboard class that
// predicts every report from the label and edge items it sees accepted.
// Depends on arc_pkg and arrangement_cutwidth.
module testbench;
  import arc_pkg::*;

  localparam int VMAX        = MAX_VERTICES_DEF;
  localparam int LABEL_TOP   = (1 << POS_W) - 1;
  localparam int SETTLE      = VMAX + 8;
  localparam int STALL_LIMIT = 10000;
  localparam int RANDOM_ITEMS = 580;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int PHASE_SIZES [10] = '{1, 7, 2, 16, 0, 33, 1025, 3, 64, 1024};

  class cutwidth_board;
    logic [POS_W-1:0]     slot_of [VMAX];
    logic [CNT_VAL_W-1:0] cut_tally [VMAX];
    logic [POS_W-1:0]     size_reg;
    logic [OUT_W-1:0]     pending_cuts [$];
    int                   errors;

    function new();
      size_reg = '0;
      errors = 0;
      foreach (slot_of[i]) slot_of[i] = '0;
      foreach (cut_tally[i]) cut_tally[i] = '0;
    endfunction

    function void set_size(logic [POS_W-1:0] v);
      size_reg = v;
    endfunction

    function int pending();
      return pending_cuts.size();
    endfunction

    // called for every accepted item transfer
    function void note_item(logic [OP_W-1:0] op, logic [VERT_W-1:0] va,
                            logic [VERT_W-1:0] vb, logic [POS_W-1:0] lab);
      int unsigned live, lo, hi, p, best;
      logic [OUT_W-1:0] want;
      live = (size_reg > VMAX) ? VMAX : size_reg;
      case (op)
        OP_SET_LABEL: slot_of[va] = lab;
        OP_ADD_EDGE: begin
          lo = slot_of[va];
          hi = slot_of[vb];
          if (lo > hi) begin
            p = lo;
            lo = hi;
            hi = p;
          end
          for (int j = 0; j < live; j++) begin
            p = slot_of[j];
            // positions past the counter array have no counter
            if (p >= lo && p < hi && p < VMAX && cut_tally[p] != COUNT_MAX)
              cut_tally[p] = cut_tally[p] + 1'b1;
          end
        end
        OP_REPORT: begin
          best = 0;
          for (int j = 0; j < live; j++)
            if (cut_tally[j] > best) best = cut_tally[j];
          if (live == 0) want = '1;
          else want = best[OUT_W-1:0];
          pending_cuts = {pending_cuts, want};
          foreach (cut_tally[j]) cut_tally[j] = '0;
        end
        default: ;
      endcase
    endfunction

    function void check_cut(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      if (pending_cuts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("max_cut %0d with no report pending", $signed(got));
        return;
      end
      want = pending_cuts.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("max_cut mismatch: expected %0d got %0d", $signed(want), $signed(got));
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OP_W-1:0]         in_operation = '0;
  logic [VERT_W-1:0]       in_vertex_a = '0;
  logic [VERT_W-1:0]       in_vertex_b = '0;
  logic [POS_W-1:0]        in_label = '0;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_max_cut;
  logic                    cfg_wr_en = 1'b0;
  logic [POS_W-1:0]        cfg_wr_data = '0;

  cutwidth_board sb = new();
  int          stall_cycles = 0;
  int          idle_pct = 0;
  int unsigned sent = 0;
  int unsigned live_now = 0;

  arrangement_cutwidth u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_operation (in_operation),
    .in_vertex_a  (in_vertex_a),
    .in_vertex_b  (in_vertex_b),
    .in_label     (in_label),
    .out_valid    (out_valid),
    .out_max_cut  (out_max_cut),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid || cfg_wr_en)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_n && cfg_wr_en) sb.set_size(cfg_wr_data);
    if (rst_n && start && !busy)
      sb.note_item(in_operation, in_vertex_a, in_vertex_b, in_label);
    if (rst_n && out_valid) sb.check_cut(out_max_cut);
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // leaves start high on return so the next item can follow without a gap
  task automatic send(logic [OP_W-1:0] op, logic [VERT_W-1:0] va,
                      logic [VERT_W-1:0] vb, logic [POS_W-1:0] lab);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_vertex_a  <= va;
    in_vertex_b  <= vb;
    in_label     <= lab;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic label(logic [VERT_W-1:0] v, logic [POS_W-1:0] lab);
    send(OP_SET_LABEL, v, VERT_W'($urandom()), lab);
  endtask

  task automatic link(logic [VERT_W-1:0] a, logic [VERT_W-1:0] b);
    send(OP_ADD_EDGE, a, b, POS_W'($urandom()));
  endtask

  task automatic ask_cut();
    send(OP_REPORT, VERT_W'($urandom()), VERT_W'($urandom()), POS_W'($urandom()));
  endtask

  task automatic junk_op();
    send(OP_UNUSED, VERT_W'($urandom()), VERT_W'($urandom()), POS_W'($urandom()));
  endtask

  // edges give no result, so a walk may still run after the last report arrived
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(logic [POS_W-1:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    live_now = (v > VMAX) ? VMAX : v;
  endtask

  function automatic logic [VERT_W-1:0] pick_vertex();
    if (live_now > 0 && $urandom_range(4) != 0) return VERT_W'($urandom_range(live_now - 1));
    return VERT_W'($urandom_range(VMAX - 1));
  endfunction

  function automatic logic [POS_W-1:0] pick_label();
    if (live_now > 0 && $urandom_range(9) != 0) return POS_W'($urandom_range(live_now - 1));
    return POS_W'($urandom_range(LABEL_TOP));
  endfunction

  // relabel a few vertices, add some edges, then read and clear the counters
  task automatic arrangement_round();
    int relabels, links;
    relabels = $urandom_range(6);
    links = (live_now > 64) ? $urandom_range(2) : $urandom_range(8);
    repeat (relabels) label(pick_vertex(), pick_label());
    repeat (links) begin
      link(pick_vertex(), pick_vertex());
      if ($urandom_range(19) == 0) junk_op();
    end
    ask_cut();
    if ($urandom_range(7) == 0) ask_cut();
  endtask

  initial begin
    int unsigned phase_end;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // no positions in use after reset: report gives -1
    ask_cut();
    junk_op();
    write_size(4);
    for (int v = 0; v < 4; v++) label(VERT_W'(v), POS_W'(v));
    link(0, 3);
    link(3, 0);
    link(1, 1);
    ask_cut();
    ask_cut();
    // positions at or past the counter array span the edge but count nowhere
    label(1, POS_W'(VMAX));
    label(2, 1500);
    label(3, POS_W'(LABEL_TOP));
    link(0, 3);
    ask_cut();

    // full size via an oversized register; piling every vertex but the last on one position
    // drives that counter into saturation
    write_size(POS_W'(LABEL_TOP));
    for (int v = 0; v < VMAX; v++)
      label(VERT_W'(v), (v == VMAX - 1) ? POS_W'(1) : POS_W'(0));
    repeat (66) link(0, VERT_W'(VMAX - 1));
    ask_cut();

    phase_end = sent;
    for (int k = 0; k < 10; k++) begin
      write_size(POS_W'(PHASE_SIZES[k]));
      idle_pct = (k % 3 == 0) ? 0 : (k % 3 == 1) ? 75 : 8;
      phase_end += RANDOM_ITEMS / 10;
      while (sent < phase_end) arrangement_round();
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
